[rtl/wavp_pkg.sv]
// shared types and constants for the wav pcm16 stream parser
package wavp_pkg;

  // input item kinds carried in the slave tuser bit
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // chunk tags, first file byte in the high bits
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BYTES   = 32'd16;
  localparam logic [15:0] PCM_CODE    = 16'd1;
  localparam logic [15:0] SAMPLE_BITS = 16'd16;
  localparam logic [15:0] MONO_CHANS  = 16'd1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_EOA    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_BAD_RIFF      = 3'd1,
    ERR_FMT_SMALL     = 3'd2,
    ERR_FMT_TRUNCATED = 3'd3,
    ERR_FMT_MISSING   = 3'd4,
    ERR_NOT_PCM       = 3'd5,
    ERR_NOT_16BIT     = 3'd6
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic [31:0]        payload_length;
    err_e               error_code;
  } result_t;

endpackage

[rtl/wavp_parser.sv]
// byte-wise riff/wave header walker and pcm frame assembler
module wavp_parser import wavp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_cmd_i,
  input  logic [7:0] in_byte_i,
  output logic    res_valid_o,
  output result_t res_o
);

  typedef enum logic [2:0] {
    PH_RIFF  = 3'd0,
    PH_CHDR  = 3'd1,
    PH_FMT   = 3'd2,
    PH_SKIP  = 3'd3,
    PH_AUDIO = 3'd4,
    PH_HALT  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [15:0] fmt_code_q, fmt_code_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [23:0] frame_q, frame_d;
  logic [1:0]  fidx_q, fidx_d;

  logic [31:0] tag_shift;
  logic [31:0] len_lane;
  logic [31:0] len_dec;
  logic [31:0] fmt_rest;
  err_e        hdr_err;
  logic        mono;

  assign tag_shift = {tag_q[23:0], in_byte_i};
  assign len_lane  = len_q | ({24'b0, in_byte_i} << {cnt_q[1:0], 3'b000});
  assign len_dec   = len_q - 32'd1;
  assign fmt_rest  = len_q - FMT_BYTES;
  assign mono      = (chans_q == MONO_CHANS);

  // validation order: fmt missing, then format code, then sample width
  always_comb begin
    priority if (!fmt_seen_q)           hdr_err = ERR_FMT_MISSING;
    else if (fmt_code_q != PCM_CODE)    hdr_err = ERR_NOT_PCM;
    else if (bits_q != SAMPLE_BITS)     hdr_err = ERR_NOT_16BIT;
    else                                hdr_err = ERR_NONE;
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    tag_d      = tag_q;
    len_d      = len_q;
    hdr_ok_d   = hdr_ok_q;
    fmt_code_d = fmt_code_q;
    chans_d    = chans_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    fmt_seen_d = fmt_seen_q;
    frame_d    = frame_q;
    fidx_d     = fidx_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (in_valid_i) begin
      if (in_cmd_i == CMD_END) begin
        unique case (phase_q)
          PH_RIFF: begin
            phase_d = PH_HALT;
            res_valid_o = 1'b1;
            res_o.kind = KIND_ERROR;
            res_o.error_code = ERR_BAD_RIFF;
          end
          PH_CHDR, PH_SKIP: begin
            phase_d = PH_HALT;
            res_valid_o = 1'b1;
            if (hdr_err != ERR_NONE) begin
              res_o.kind = KIND_ERROR;
              res_o.error_code = hdr_err;
            end else begin
              res_o.kind = KIND_HEADER;
              res_o.rate_hz = rate_q;
              res_o.channel_count = chans_q;
            end
          end
          PH_FMT: begin
            phase_d = PH_HALT;
            res_valid_o = 1'b1;
            res_o.kind = KIND_ERROR;
            res_o.error_code = ERR_FMT_TRUNCATED;
          end
          PH_AUDIO: begin
            phase_d = PH_HALT;
            frame_d = '0;
            fidx_d  = '0;
            res_valid_o = 1'b1;
            res_o.kind = KIND_EOA;
          end
          default: ;
        endcase
      end else begin
        unique case (phase_q)
          PH_RIFF: begin
            tag_d = tag_shift;
            if (cnt_q == 4'd3 && tag_shift != TAG_RIFF) hdr_ok_d = 1'b0;
            if (cnt_q == 4'd11) begin
              if (!hdr_ok_q || tag_shift != TAG_WAVE) begin
                phase_d = PH_HALT;
                res_valid_o = 1'b1;
                res_o.kind = KIND_ERROR;
                res_o.error_code = ERR_BAD_RIFF;
              end else begin
                phase_d = PH_CHDR;
                cnt_d = '0;
                tag_d = '0;
                len_d = '0;
              end
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
          PH_CHDR: begin
            if (!cnt_q[2]) begin
              tag_d = tag_shift;
              cnt_d = cnt_q + 4'd1;
            end else if (cnt_q != 4'd7) begin
              len_d = len_lane;
              cnt_d = cnt_q + 4'd1;
            end else begin
              len_d = len_lane;
              if (tag_q == TAG_FMT) begin
                if (len_lane < FMT_BYTES) begin
                  phase_d = PH_HALT;
                  res_valid_o = 1'b1;
                  res_o.kind = KIND_ERROR;
                  res_o.error_code = ERR_FMT_SMALL;
                end else begin
                  phase_d = PH_FMT;
                  cnt_d = '0;
                end
              end else if (tag_q == TAG_DATA) begin
                res_valid_o = 1'b1;
                if (hdr_err != ERR_NONE) begin
                  phase_d = PH_HALT;
                  res_o.kind = KIND_ERROR;
                  res_o.error_code = hdr_err;
                end else begin
                  phase_d = PH_AUDIO;
                  frame_d = '0;
                  fidx_d  = '0;
                  res_o.kind = KIND_HEADER;
                  res_o.rate_hz = rate_q;
                  res_o.channel_count = chans_q;
                  res_o.payload_length = len_lane;
                end
              end else if (len_lane == 32'd0) begin
                cnt_d = '0;
                tag_d = '0;
                len_d = '0;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_FMT: begin
            unique case (cnt_q)
              4'd0:    fmt_code_d = {8'b0, in_byte_i};
              4'd1:    fmt_code_d[15:8] = in_byte_i;
              4'd2:    chans_d = {8'b0, in_byte_i};
              4'd3:    chans_d[15:8] = in_byte_i;
              4'd4:    rate_d = {24'b0, in_byte_i};
              4'd5:    rate_d[15:8] = in_byte_i;
              4'd6:    rate_d[23:16] = in_byte_i;
              4'd7:    rate_d[31:24] = in_byte_i;
              4'd14:   bits_d = {8'b0, in_byte_i};
              4'd15:   bits_d[15:8] = in_byte_i;
              default: ;
            endcase
            if (cnt_q == 4'd15) begin
              fmt_seen_d = 1'b1;
              if (fmt_rest == 32'd0) begin
                phase_d = PH_CHDR;
                cnt_d = '0;
                tag_d = '0;
                len_d = '0;
              end else begin
                phase_d = PH_SKIP;
                len_d = fmt_rest;
              end
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
          PH_SKIP: begin
            len_d = len_dec;
            if (len_dec == 32'd0) begin
              phase_d = PH_CHDR;
              cnt_d = '0;
              tag_d = '0;
            end
          end
          PH_AUDIO: begin
            if (mono && fidx_q == 2'd1) begin
              frame_d = '0;
              fidx_d  = '0;
              res_valid_o = 1'b1;
              res_o.kind = KIND_FRAME;
              res_o.left_sample  = {in_byte_i, frame_q[7:0]};
              res_o.right_sample = {in_byte_i, frame_q[7:0]};
            end else if (!mono && fidx_q == 2'd3) begin
              frame_d = '0;
              fidx_d  = '0;
              res_valid_o = 1'b1;
              res_o.kind = KIND_FRAME;
              res_o.left_sample  = frame_q[15:0];
              res_o.right_sample = {in_byte_i, frame_q[23:16]};
            end else begin
              unique case (fidx_q)
                2'd0:    frame_d[7:0]   = frame_q[7:0]   | in_byte_i;
                2'd1:    frame_d[15:8]  = frame_q[15:8]  | in_byte_i;
                2'd2:    frame_d[23:16] = frame_q[23:16] | in_byte_i;
                default: ;
              endcase
              fidx_d = fidx_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF;
      cnt_q      <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      hdr_ok_q   <= 1'b1;
      fmt_code_q <= '0;
      chans_q    <= '0;
      rate_q     <= '0;
      bits_q     <= '0;
      fmt_seen_q <= 1'b0;
      frame_q    <= '0;
      fidx_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      hdr_ok_q   <= hdr_ok_d;
      fmt_code_q <= fmt_code_d;
      chans_q    <= chans_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      fmt_seen_q <= fmt_seen_d;
      frame_q    <= frame_d;
      fidx_q     <= fidx_d;
    end
  end

endmodule

[rtl/wavp_out_buf.sv]
// result register with one skid entry toward the master side
module wavp_out_buf import wavp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_data_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    main_free;

  assign main_free = !main_valid_q || m_ready_i;
  assign ready_o   = !skid_valid_q;
  assign m_valid_o = main_valid_q;
  assign m_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // skid only fills behind a held result
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry valid without a held result");

  // no push may land while the skid entry is occupied
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed while skid entry full");

  // a drained skid entry moves into the result register
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_ready_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid entry lost on drain");

endmodule

[rtl/wav_pcm16_stream_parser.sv]
// top level of the wav pcm16 stream parser
// Takes a WAV file one byte per transfer (tuser low) and an end-of-stream
// marker (tuser high), one transfer per clock with no gaps required. Each
// byte only updates counters, tags, lengths, fmt fields or the frame being
// assembled inside the parser, so a byte is absorbed in the cycle it is
// accepted; any result is registered for the master. s_axis_tready_o drops only
// when the output register is held by back pressure and its one skid entry
// is also full; a steady one transfer per cycle is sustained whenever the
// master side takes results. Results: a header (rate, channel count, data
// length, the latter 0 if the stream ended before a data chunk), an error
// code, 16-bit stereo frames (mono copied to both channels), and an end of
// audio marker. After an error, a header at end of stream, or end of audio
// the block ignores all input until reset.
module wav_pcm16_stream_parser import wavp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte[7:0]
  input  logic         s_axis_tuser_i,   // cmd[0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // left_sample[15:0], right_sample[31:16], rate_hz[63:32],
  // channel_count[79:64], payload_length[111:80], error_code[114:112], zero pad
  output logic [119:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o    // kind[1:0]
);

  logic    in_xfer;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // input transfer completes on valid and ready
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  wavp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .in_cmd_i    (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register plus skid entry decouples the two sides
  wavp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (out_res)
  );

  // pack result fields from the lowest bit up
  assign m_axis_tdata_o = {5'b0,
                           out_res.error_code,
                           out_res.payload_length,
                           out_res.channel_count,
                           out_res.rate_hz,
                           out_res.right_sample,
                           out_res.left_sample};
  assign m_axis_tuser_o = out_res.kind;

endmodule
